// ----- hw/rtl/g2h_pkg.sv -----
// Shared types, constants and table functions for the Gregorian to Hijri converter.
package g2h_pkg;

  typedef struct packed {
    logic [4:0]  greg_day;
    logic [3:0]  greg_month;
    logic [13:0] greg_year;
  } g2h_req_t;

  typedef struct packed {
    logic [4:0]  hijri_day;
    logic [3:0]  hijri_month;
    logic [13:0] hijri_year;
  } g2h_res_t;

  typedef struct packed {
    logic load;
    logic abs1;
    logic abs2;
    logic est;
    logic rec;
    logic syr;
    logic ystep;
    logic mstep;
    logic set_sat;
  } g2h_cmd_t;

  typedef struct packed {
    logic sat;
    logic year_done;
    logic month_done;
  } g2h_status_t;

  localparam logic [22:0] EPOCH_DAYS     = 23'd227014;
  localparam logic [22:0] HIJRI_YEAR_LEN = 23'd354;
  localparam logic [26:0] RECIP_100      = 27'd5243;      // 2^19 / 100, rounded up
  localparam logic [46:0] RECIP_355      = 47'd12098500;  // 2^32 / 355, rounded up
  localparam logic [36:0] RECIP_30       = 37'd279621;    // 2^23 / 30, rounded up
  localparam logic [4:0]  LEAP_RESIDUE   = 5'd19;
  localparam logic [3:0]  LAST_MONTH     = 4'd12;

  // Days of the Gregorian months before month m in a common year.
  // Months above twelve count as 31 days each.
  function automatic logic [8:0] greg_cum(input logic [3:0] m);
    logic [8:0] v;
    unique case (m)
      4'd0, 4'd1: v = 9'd0;
      4'd2:       v = 9'd31;
      4'd3:       v = 9'd59;
      4'd4:       v = 9'd90;
      4'd5:       v = 9'd120;
      4'd6:       v = 9'd151;
      4'd7:       v = 9'd181;
      4'd8:       v = 9'd212;
      4'd9:       v = 9'd243;
      4'd10:      v = 9'd273;
      4'd11:      v = 9'd304;
      4'd12:      v = 9'd334;
      4'd13:      v = 9'd365;
      4'd14:      v = 9'd396;
      default:    v = 9'd427;
    endcase
    return v;
  endfunction

  // Offset of the first day of Islamic month mo from the start of the year.
  function automatic logic [8:0] month_start(input logic [3:0] mo);
    logic [8:0] v;
    unique case (mo)
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd30;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd89;
      4'd5:    v = 9'd118;
      4'd6:    v = 9'd148;
      4'd7:    v = 9'd177;
      4'd8:    v = 9'd207;
      4'd9:    v = 9'd236;
      4'd10:   v = 9'd266;
      4'd11:   v = 9'd295;
      4'd12:   v = 9'd325;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/g2h_ctrl.sv -----
// Sequencing state machine of the Gregorian to Hijri converter.
module g2h_ctrl import g2h_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  g2h_status_t status_i,
  output g2h_cmd_t    cmd_o,
  output logic        busy,
  output logic        result_valid_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ABS1  = 9'b000000010,
    S_ABS2  = 9'b000000100,
    S_EST   = 9'b000001000,
    S_REC   = 9'b000010000,
    S_SYR   = 9'b000100000,
    S_YSRCH = 9'b001000000,
    S_MSRCH = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_ABS1;
        end
      end
      S_ABS1: begin
        cmd_o.abs1 = 1'b1;
        state_d    = S_ABS2;
      end
      S_ABS2: begin
        cmd_o.abs2 = 1'b1;
        state_d    = S_EST;
      end
      S_EST: begin
        cmd_o.est = 1'b1;
        // Dates on or before the epoch skip the searches entirely.
        if (status_i.sat) begin
          cmd_o.set_sat = 1'b1;
          state_d       = S_DONE;
        end else begin
          state_d = S_REC;
        end
      end
      S_REC: begin
        cmd_o.rec = 1'b1;
        state_d   = S_SYR;
      end
      S_SYR: begin
        cmd_o.syr = 1'b1;
        state_d   = S_YSRCH;
      end
      S_YSRCH: begin
        cmd_o.ystep = 1'b1;
        if (status_i.year_done) state_d = S_MSRCH;
      end
      S_MSRCH: begin
        cmd_o.mstep = 1'b1;
        if (status_i.month_done) state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_DONE);

endmodule

// ----- hw/rtl/g2h_datapath.sv -----
// Arithmetic datapath: day count, year estimate, year and month searches.
module g2h_datapath import g2h_pkg::*; (
  input  logic        clk_i,
  input  g2h_req_t    req_i,
  input  g2h_cmd_t    cmd_i,
  output g2h_status_t status_o,
  output g2h_res_t    result_o
);

  logic [4:0]  day_q;
  logic [3:0]  mon_q;
  logic [13:0] ym1_q;
  logic        yzero_q;
  logic [7:0]  qa_q;
  logic [22:0] base_q;
  logic [22:0] n_q;
  logic [13:0] yr_q;
  logic [17:0] t_q;
  logic [12:0] qt_q;
  logic [4:0]  r_q;
  logic [22:0] s_q;
  logic [8:0]  off_q;
  logic [3:0]  mo_q;
  g2h_res_t    res_q;

  logic [26:0] prod_a;
  logic [22:0] base_d;
  logic [13:0] ra;
  logic        leap_g;
  logic [22:0] n_d;
  logic [46:0] prod_e;
  logic [17:0] t_d;
  logic [36:0] prod_t;
  logic [17:0] r_full;
  logic [22:0] s_d;
  logic        leap_h;
  logic [22:0] s_next;
  logic [4:0]  r_next;
  logic [22:0] off_full;
  logic        mo_adv;
  logic [8:0]  hd_full;

  // Day count: (y-1)/100 by reciprocal, (y-1)/400 as that quotient over four.
  assign prod_a = 27'(ym1_q) * RECIP_100;
  assign base_d = 23'(ym1_q) * 23'd365 + 23'(ym1_q >> 2);
  assign ra     = ym1_q - 14'(qa_q) * 14'd100;
  // y is a leap year: y-1 ends in binary 11, and century years need y/100 divisible by four.
  assign leap_g = ((ym1_q[1:0] == 2'b11) && (ra != 14'd99)) ||
                  ((ra == 14'd99) && (qa_q[1:0] == 2'b11));
  assign n_d    = 23'(day_q) + 23'(greg_cum(mon_q)) + 23'(leap_g && (mon_q >= 4'd3))
                + base_q - 23'(qa_q) + 23'(qa_q >> 2);

  // Year estimate and the start of that year.
  assign prod_e = 47'(n_q - EPOCH_DAYS) * RECIP_355;
  assign t_d    = 18'(yr_q) * 18'd11 + 18'd3;
  assign prod_t = 37'(t_d) * RECIP_30;
  assign r_full = t_q - 18'(qt_q) * 18'd30;
  assign s_d    = 23'(yr_q) * HIJRI_YEAR_LEN + 23'(qt_q) + (EPOCH_DAYS - 23'd353);

  // The residue of 11*yr+3 modulo 30 tracks leap years while stepping.
  assign leap_h   = (r_q >= LEAP_RESIDUE);
  assign s_next   = s_q + HIJRI_YEAR_LEN + 23'(leap_h);
  assign r_next   = leap_h ? (r_q - LEAP_RESIDUE) : (r_q + 5'd11);
  assign off_full = n_q - s_q;

  assign mo_adv  = (mo_q < LAST_MONTH) && (off_q >= month_start(mo_q + 4'd1));
  assign hd_full = off_q - month_start(mo_q) + 9'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      day_q   <= req_i.greg_day;
      mon_q   <= req_i.greg_month;
      ym1_q   <= req_i.greg_year - 14'd1;
      yzero_q <= (req_i.greg_year == 14'd0);
    end
    if (cmd_i.abs1) begin
      qa_q   <= prod_a[26:19];
      base_q <= base_d;
    end
    if (cmd_i.abs2) begin
      n_q <= n_d;
    end
    if (cmd_i.est) begin
      yr_q <= prod_e[45:32];
    end
    if (cmd_i.rec) begin
      t_q  <= t_d;
      qt_q <= prod_t[35:23];
    end
    if (cmd_i.syr) begin
      r_q <= r_full[4:0];
      s_q <= s_d;
    end
    if (cmd_i.ystep) begin
      if (n_q >= s_next) begin
        s_q  <= s_next;
        r_q  <= r_next;
        yr_q <= yr_q + 14'd1;
      end else begin
        off_q <= off_full[8:0];
        mo_q  <= 4'd1;
      end
    end
    if (cmd_i.mstep) begin
      if (mo_adv) begin
        mo_q <= mo_q + 4'd1;
      end else begin
        res_q.hijri_day   <= hd_full[4:0];
        res_q.hijri_month <= mo_q;
        res_q.hijri_year  <= yr_q;
      end
    end
    if (cmd_i.set_sat) begin
      res_q.hijri_day   <= 5'd1;
      res_q.hijri_month <= 4'd1;
      res_q.hijri_year  <= 14'd1;
    end
  end

  assign status_o.sat        = yzero_q || (n_q <= EPOCH_DAYS);
  assign status_o.year_done  = (n_q < s_next);
  assign status_o.month_done = !mo_adv;
  assign result_o            = res_q;

endmodule

// ----- hw/rtl/gregorian_to_hijri_date_core.sv -----
// Sequence: after the request is taken, the states ABS1, ABS2, EST, REC and SYR run, then
// the year search steps from the estimate and the month search steps up to the Islamic month.
// Dates on or before the epoch skip both searches. The year and month searches, one step
// per cycle, set how long a request takes; a new request is taken the cycle after the strobe.
// The receiver cannot stall; the strobe lasts one cycle. Reset clears the controller only.
// Top level of the Gregorian to arithmetical Islamic date converter.
module gregorian_to_hijri_date_core import g2h_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  g2h_req_t req_i,
  output logic     busy,
  output logic     result_valid_o,
  output g2h_res_t result_o
);

  g2h_cmd_t    cmd;
  g2h_status_t status;

  g2h_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  g2h_datapath u_datapath (
    .clk_i    (clk_i),
    .req_i    (req_i),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (result_o)
  );

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !result_valid_o))
    else $error("accepted request did not start processing");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ((result_o.hijri_month >= 4'd1) && (result_o.hijri_month <= 4'd12)
                        && (result_o.hijri_day != 5'd0)))
    else $error("result month or day out of range");
`endif

endmodule
